[rtl/core/shadow_stack_return_check_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the shadow stack return check core
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SHADOW_STACK_RETURN_CHECK_CORE_DEFINES_SVH
`define SHADOW_STACK_RETURN_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define SSRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ssrc assertion failed");

// Next-cycle implication, disabled while reset is held
`define SSRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ssrc assertion failed");

`endif

[rtl/core/ssrc_pkg.sv]
// ----------------------------------------------------------------------------
// ssrc_pkg
// Constants and types shared by the shadow stack return check core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssrc_pkg;

    // Stack geometry
    localparam int unsigned STACK_DEPTH = 1024;
    localparam int unsigned ADDR_W      = 64;
    localparam int unsigned ADDR_IN_W   = 64;
    localparam int unsigned DEPTH_W     = 11;
    localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int unsigned RAM_AW      = $clog2(STACK_DEPTH);

    // Command codes
    localparam logic CMD_CALL   = 1'b0;
    localparam logic CMD_RETURN = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Word handed from the pointer stage to the compare stage
    typedef struct packed {
        logic                vld;
        logic                chk;
        logic [ADDR_W-1:0]   addr;
        status_t             status;
        logic [DEPTH_W-1:0]  depth;
    } issue_t;

endpackage

`default_nettype wire

[rtl/core/ssrc_ram.sv]
// ----------------------------------------------------------------------------
// ssrc_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrc_ram #(
    parameter  int unsigned WIDTH = 64,
    parameter  int unsigned DEPTH = 1024,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, output holds while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/core/ssrc_ptr.sv]
// ----------------------------------------------------------------------------
// ssrc_ptr
// Stack pointer stage: accepts words, updates the pointer, drives the stack RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrc_ptr (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [ssrc_pkg::ADDR_IN_W-1:0] s_return_address,
    input  wire logic                          take,
    output ssrc_pkg::issue_t                   issue,
    output logic                               ram_we,
    output logic      [ssrc_pkg::RAM_AW-1:0]   ram_waddr,
    output logic      [ssrc_pkg::ADDR_W-1:0]   ram_wdata,
    output logic                               ram_re,
    output logic      [ssrc_pkg::RAM_AW-1:0]   ram_raddr
);
    import ssrc_pkg::*;

    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_next;
    logic            accept;
    logic            full;
    logic            empty;

    assign s_ready = take;
    assign accept  = s_valid && take;
    assign full    = (sp_reg == SP_W'(STACK_DEPTH));
    assign empty   = (sp_reg == '0);

    // Decide pointer move, RAM access and early status
    always_comb begin
        sp_next      = sp_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        issue.vld    = accept;
        issue.chk    = 1'b0;
        issue.addr   = s_return_address[ADDR_W-1:0];
        issue.status = ST_OK;
        if (s_cmd == CMD_CALL) begin
            if (full) begin
                issue.status = ST_OVERFLOW;
            end else begin
                ram_we  = accept;
                sp_next = sp_reg + SP_W'(1);
            end
        end else begin
            if (empty) begin
                issue.status = ST_UNDERFLOW;
            end else begin
                ram_re    = accept;
                issue.chk = 1'b1;
                sp_next   = sp_reg - SP_W'(1);
            end
        end
        issue.depth = DEPTH_W'(sp_next);
    end

    // Push writes at the current top, pop reads one below it
    assign ram_waddr = sp_reg[RAM_AW-1:0];
    assign ram_wdata = s_return_address[ADDR_W-1:0];
    assign ram_raddr = sp_next[RAM_AW-1:0];

    // Advance the pointer on accepted words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
        end else if (accept) begin
            sp_reg <= sp_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/ssrc_cmp.sv]
// ----------------------------------------------------------------------------
// ssrc_cmp
// Compare stage and output register: checks the popped entry, holds results.
// ----------------------------------------------------------------------------
`default_nettype none

module ssrc_cmp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ssrc_pkg::issue_t              issue,
    input  wire logic [ssrc_pkg::ADDR_W-1:0]   ram_rdata,
    output logic                               take,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [1:0]                    m_status,
    output logic      [ssrc_pkg::DEPTH_W-1:0]  m_depth
);
    import ssrc_pkg::*;

    issue_t             s1_reg;
    logic               s1_vld_reg;
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [DEPTH_W-1:0] m_depth_reg;
    logic               out_free;
    logic               s1_adv;
    status_t            s1_status;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_vld_reg && out_free;
    assign take     = !s1_vld_reg || out_free;

    // Resolve the return check against the RAM word
    always_comb begin
        s1_status = s1_reg.status;
        if (s1_reg.chk) begin
            s1_status = (ram_rdata == s1_reg.addr) ? ST_OK : ST_MISMATCH;
        end
    end

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                s1_vld_reg <= issue.vld;
            end
            if (out_free) begin
                m_valid_reg <= s1_vld_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (take && issue.vld) begin
            s1_reg <= issue;
        end
        if (s1_adv) begin
            m_status_reg <= s1_status;
            m_depth_reg  <= s1_reg.depth;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_depth  = m_depth_reg;

endmodule

`default_nettype wire

[rtl/core/shadow_stack_return_check_core.sv]
// An accepted word goes through the compare register, then the output register.
// Throughput: one call or return per cycle when not stalled; each word does at most
// one stack RAM access (calls write, returns read); the pointer loop sets the rate.
// Reset: synchronous, active low; clears the stack pointer and the valid flags.
// The stack RAM is not cleared; entries at or above the pointer are never read.
// ----------------------------------------------------------------------------
// shadow_stack_return_check_core
// Hardware shadow stack: pushes return addresses on calls, checks them on returns.
// ----------------------------------------------------------------------------
`default_nettype none

module shadow_stack_return_check_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_cmd,
    input  wire logic [ssrc_pkg::ADDR_IN_W-1:0] s_return_address,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [1:0]                     m_status,
    output logic      [ssrc_pkg::DEPTH_W-1:0]   m_depth
);
    import ssrc_pkg::*;

    issue_t              issue;
    logic                take;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [ADDR_W-1:0]   ram_rdata;

    // Pointer stage
    ssrc_ptr u_ptr (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_return_address (s_return_address),
        .take             (take),
        .issue            (issue),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr)
    );

    // Stack storage
    ssrc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare and output stage
    ssrc_cmp u_cmp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .ram_rdata (ram_rdata),
        .take      (take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_depth   (m_depth)
    );

endmodule

`default_nettype wire

[rtl/core/ssrc_checker.sv]
// ----------------------------------------------------------------------------
// ssrc_checker
// Port-level checks for the shadow stack return check core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shadow_stack_return_check_core_defines.svh"

module ssrc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire logic                           s_cmd,
    input wire logic [ssrc_pkg::ADDR_IN_W-1:0] s_return_address,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire logic [1:0]                     m_status,
    input wire logic [ssrc_pkg::DEPTH_W-1:0]   m_depth
);
    import ssrc_pkg::*;

    // Hold a stalled result word
    `SSRC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_depth))
    // Overflow leaves the stack full
    `SSRC_ASSERT_NOW(a_ovf_depth, m_valid && (m_status == ST_OVERFLOW), m_depth == DEPTH_W'(STACK_DEPTH))
    // Underflow leaves the stack empty
    `SSRC_ASSERT_NOW(a_udf_depth, m_valid && (m_status == ST_UNDERFLOW), m_depth == '0)

endmodule

bind shadow_stack_return_check_core ssrc_checker u_ssrc_checker (.*);

`default_nettype wire
